// ===== src/i2cm_pkg.sv =====
// Shared types, codes and sizes of the I2C master transfer sequencer.
`default_nettype none
package i2cm_pkg;

    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned ADDR_W   = 7;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned FLAGS_W  = 6;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ACTION_W = 4;
    localparam int unsigned CODE_W   = 3;

    // Input item selectors.
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EVENT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ERROR = 2'd2;

    // Bit positions of the peripheral status flags.
    localparam int unsigned FLAG_SB   = 0;
    localparam int unsigned FLAG_ADDR = 1;
    localparam int unsigned FLAG_BTF  = 2;
    localparam int unsigned FLAG_TXE  = 3;
    localparam int unsigned FLAG_RXNE = 4;
    localparam int unsigned FLAG_MSL  = 5;
    localparam int unsigned ERR_KINDS = 5;

    // Busy reply codes: state seen when the start request arrived.
    localparam logic [CODE_W-1:0] BUSY_READY = 3'd0;
    localparam logic [CODE_W-1:0] BUSY_TX    = 3'd1;
    localparam logic [CODE_W-1:0] BUSY_RX    = 3'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_BUSY    = 4'd0,
        ACT_START   = 4'd1,
        ACT_WRITE   = 4'd2,
        ACT_ACK     = 4'd3,
        ACT_CLRADDR = 4'd4,
        ACT_STOP    = 4'd5,
        ACT_RXBYTE  = 4'd6,
        ACT_TXDONE  = 4'd7,
        ACT_RXDONE  = 4'd8,
        ACT_ERROR   = 4'd9
    } t_action;

    typedef enum logic [2:0] {
        ST_READY = 3'b001,
        ST_TX    = 3'b010,
        ST_RX    = 3'b100
    } t_xfer_state;

    // Fixed slot of every action a start or event item can produce, in output order.
    localparam int unsigned SLOT_COUNT    = 12;
    localparam int unsigned SLOT_START    = 0;
    localparam int unsigned SLOT_BUSY     = 1;
    localparam int unsigned SLOT_SB       = 0;
    localparam int unsigned SLOT_ADDR_ACK = 1;
    localparam int unsigned SLOT_CLRADDR  = 2;
    localparam int unsigned SLOT_TX_STOP  = 3;
    localparam int unsigned SLOT_TX_ACK   = 4;
    localparam int unsigned SLOT_TX_DONE  = 5;
    localparam int unsigned SLOT_TX_BYTE  = 6;
    localparam int unsigned SLOT_RX_NACK  = 7;
    localparam int unsigned SLOT_RX_BYTE  = 8;
    localparam int unsigned SLOT_RX_STOP  = 9;
    localparam int unsigned SLOT_RX_ACK   = 10;
    localparam int unsigned SLOT_RX_DONE  = 11;
    localparam int unsigned SLOT_IDX_W    = $clog2(SLOT_COUNT);

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        t_action             action;
        logic [BYTE_W-1:0]   data;
        logic [CODE_W-1:0]   code;
    } t_act;

    typedef struct packed {
        logic [SLOT_COUNT-1:0] mask;
        t_act [SLOT_COUNT-1:0] slots;
    } t_entry;

endpackage
`default_nettype wire

// ===== src/i2cm_if.sv =====
// Handshake channel interfaces: request items, configuration writes and actions.
`default_nettype none
interface i2cm_req_if;
    logic                               valid;
    logic                               ready;
    logic [i2cm_pkg::FUNC_W-1:0]        func;
    logic                               dir_read;
    logic [i2cm_pkg::ADDR_W-1:0]        slave_addr;
    logic [i2cm_pkg::LEN_W-1:0]         length;
    logic                               rep_start;
    logic [i2cm_pkg::FLAGS_W-1:0]       status_flags;
    logic [i2cm_pkg::BYTE_W-1:0]        rx_byte;
    logic [i2cm_pkg::BYTE_W-1:0]        tx_byte;

    modport source (output valid, func, dir_read, slave_addr, length, rep_start,
                    status_flags, rx_byte, tx_byte, input ready);
    modport sink (input valid, func, dir_read, slave_addr, length, rep_start,
                  status_flags, rx_byte, tx_byte, output ready);
endinterface

interface i2cm_cfg_if;
    logic valid;
    logic ready;
    logic ack_control;

    modport source (output valid, ack_control, input ready);
    modport sink (input valid, ack_control, output ready);
endinterface

interface i2cm_rsp_if;
    logic                               valid;
    logic                               ready;
    i2cm_pkg::t_action                  action;
    logic [i2cm_pkg::BYTE_W-1:0]        data_byte;
    logic [i2cm_pkg::CODE_W-1:0]        code;
    logic                               last;

    modport source (output valid, action, data_byte, code, last, input ready);
    modport sink (input valid, action, data_byte, code, last, output ready);
endinterface
`default_nettype wire

// ===== src/i2c_master_transfer_sequencer.sv =====
// Top level of the interrupt-driven I2C master transfer sequencer.
//
// i_req carries start, peripheral event and error items; o_rsp returns the
// ordered actions each item causes, with last set on the final one; i_cfg
// writes the ack_control bit and is always ready.
// The front end classifies an item and updates the transfer state in the
// cycle it is accepted, then stores the item's whole action list in a
// two-entry queue. The back end drains the head list one action per cycle,
// unless o_rsp stalls, into the output register, so the first action goes
// through the queue and that register. Items with no action leave no trace.
// Throughput is one action per cycle while o_rsp is ready: an item with one
// action can follow every cycle, while an item with k actions holds the
// output until all k are taken; the queue holds up to two lists meanwhile.
// When o_rsp stalls the presented action holds and the front end keeps
// accepting until the queue is full, then drops i_req.ready.
// Synchronous reset empties the queue and output register, returns the
// transfer to ready with all interrupt enables off, and clears ack_control.
`default_nettype none
module i2c_master_transfer_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cm_req_if.sink    i_req,
    i2cm_cfg_if.sink    i_cfg,
    i2cm_rsp_if.source  o_rsp
);

    logic               r_ack_control;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;
    i2cm_pkg::t_entry   push_entry;
    i2cm_pkg::t_entry   head_entry;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_control <= 1'b0;
        end else if (i_cfg.valid) begin
            r_ack_control <= i_cfg.ack_control;
        end
    end

    i2cm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .i_ack_control (r_ack_control),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    i2cm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_empty (q_empty)
    );

    i2cm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_entry),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule
`default_nettype wire

// ===== src/i2cm_front.sv =====
// Front end: accepts request items, tracks the transfer and builds each item's action list.
`default_nettype none
module i2cm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    i2cm_req_if.sink            i_req,
    input  logic                i_ack_control,
    input  logic                i_q_full,
    output logic                o_push,
    output i2cm_pkg::t_entry    o_entry
);

    i2cm_pkg::t_xfer_state              r_state, n_state;
    logic [i2cm_pkg::LEN_W-1:0]         r_tx_rem, n_tx_rem;
    logic [i2cm_pkg::LEN_W-1:0]         r_rx_rem, n_rx_rem;
    logic [i2cm_pkg::LEN_W-1:0]         r_rx_total, n_rx_total;
    logic [i2cm_pkg::ADDR_W-1:0]        r_addr, n_addr;
    logic                               r_hold, n_hold;
    logic                               r_ev_irq, n_ev_irq;
    logic                               r_buf_irq, n_buf_irq;
    logic                               r_err_irq, n_err_irq;
    logic                               accept;
    i2cm_pkg::t_entry                   entry;

    function automatic i2cm_pkg::t_act mk(input i2cm_pkg::t_action a,
                                          input logic [i2cm_pkg::BYTE_W-1:0] d,
                                          input logic [i2cm_pkg::CODE_W-1:0] c);
        i2cm_pkg::t_act r;
        r.action = a;
        r.data   = d;
        r.code   = c;
        return r;
    endfunction

    function automatic logic [i2cm_pkg::CODE_W-1:0] busy_code(input i2cm_pkg::t_xfer_state s);
        logic [i2cm_pkg::CODE_W-1:0] c;
        case (s)
            i2cm_pkg::ST_TX: c = i2cm_pkg::BUSY_TX;
            i2cm_pkg::ST_RX: c = i2cm_pkg::BUSY_RX;
            default:         c = i2cm_pkg::BUSY_READY;
        endcase
        return c;
    endfunction

    assign i_req.ready = !i_q_full;
    assign accept      = i_req.valid && !i_q_full;
    assign o_push      = accept && (entry.mask != '0);
    assign o_entry     = entry;

    always_comb begin
        logic [i2cm_pkg::FLAGS_W-1:0] f;
        logic [i2cm_pkg::LEN_W-1:0]   rem_new;
        logic                         btf_close;

        f         = i_req.status_flags;
        rem_new   = r_rx_rem;
        btf_close = 1'b0;

        n_state    = r_state;
        n_tx_rem   = r_tx_rem;
        n_rx_rem   = r_rx_rem;
        n_rx_total = r_rx_total;
        n_addr     = r_addr;
        n_hold     = r_hold;
        n_ev_irq   = r_ev_irq;
        n_buf_irq  = r_buf_irq;
        n_err_irq  = r_err_irq;

        entry.mask = '0;
        for (int i = 0; i < i2cm_pkg::SLOT_COUNT; i++) begin
            entry.slots[i] = mk(i2cm_pkg::ACT_BUSY, '0, '0);
        end

        case (i_req.func)
            i2cm_pkg::FUNC_START: begin
                if (r_state != i2cm_pkg::ST_TX && r_state != i2cm_pkg::ST_RX) begin
                    if (i_req.dir_read) begin
                        n_rx_rem   = i_req.length;
                        n_rx_total = i_req.length;
                        n_state    = i2cm_pkg::ST_RX;
                    end else begin
                        n_tx_rem = i_req.length;
                        n_state  = i2cm_pkg::ST_TX;
                    end
                    n_addr    = i_req.slave_addr;
                    n_hold    = i_req.rep_start;
                    n_ev_irq  = 1'b1;
                    n_buf_irq = 1'b1;
                    n_err_irq = 1'b1;
                    entry.mask[i2cm_pkg::SLOT_START]  = 1'b1;
                    entry.slots[i2cm_pkg::SLOT_START] = mk(i2cm_pkg::ACT_START, '0, '0);
                end
                entry.mask[i2cm_pkg::SLOT_BUSY]  = 1'b1;
                entry.slots[i2cm_pkg::SLOT_BUSY] = mk(i2cm_pkg::ACT_BUSY, '0, busy_code(r_state));
            end
            i2cm_pkg::FUNC_EVENT: begin
                if (r_ev_irq) begin
                    if (f[i2cm_pkg::FLAG_SB]) begin
                        if (r_state == i2cm_pkg::ST_TX) begin
                            entry.mask[i2cm_pkg::SLOT_SB]  = 1'b1;
                            entry.slots[i2cm_pkg::SLOT_SB] =
                                mk(i2cm_pkg::ACT_WRITE, {r_addr, 1'b0}, '0);
                        end else if (r_state == i2cm_pkg::ST_RX) begin
                            entry.mask[i2cm_pkg::SLOT_SB]  = 1'b1;
                            entry.slots[i2cm_pkg::SLOT_SB] =
                                mk(i2cm_pkg::ACT_WRITE, {r_addr, 1'b1}, '0);
                        end
                    end
                    if (f[i2cm_pkg::FLAG_ADDR]) begin
                        // A single-byte read must NACK its only byte.
                        if (r_state == i2cm_pkg::ST_RX && r_rx_total == i2cm_pkg::LEN_W'(1)) begin
                            entry.mask[i2cm_pkg::SLOT_ADDR_ACK]  = 1'b1;
                            entry.slots[i2cm_pkg::SLOT_ADDR_ACK] = mk(i2cm_pkg::ACT_ACK, '0, '0);
                        end
                        entry.mask[i2cm_pkg::SLOT_CLRADDR]  = 1'b1;
                        entry.slots[i2cm_pkg::SLOT_CLRADDR] = mk(i2cm_pkg::ACT_CLRADDR, '0, '0);
                    end
                    btf_close = f[i2cm_pkg::FLAG_BTF] && f[i2cm_pkg::FLAG_TXE] &&
                                r_state == i2cm_pkg::ST_TX && r_tx_rem == '0;
                    if (btf_close) begin
                        entry.mask[i2cm_pkg::SLOT_TX_STOP]  = 1'b1;
                        entry.slots[i2cm_pkg::SLOT_TX_STOP] = mk(i2cm_pkg::ACT_STOP, '0, '0);
                        entry.mask[i2cm_pkg::SLOT_TX_ACK]   = i_ack_control;
                        entry.slots[i2cm_pkg::SLOT_TX_ACK]  =
                            mk(i2cm_pkg::ACT_ACK, i2cm_pkg::BYTE_W'(1), '0);
                        entry.mask[i2cm_pkg::SLOT_TX_DONE]  = 1'b1;
                        entry.slots[i2cm_pkg::SLOT_TX_DONE] = mk(i2cm_pkg::ACT_TXDONE, '0, '0);
                        n_tx_rem  = '0;
                        n_state   = i2cm_pkg::ST_READY;
                        n_ev_irq  = 1'b0;
                        n_buf_irq = 1'b0;
                        n_err_irq = 1'b0;
                    end
                    // A closing BTF needs a zero count, so it never meets this branch.
                    if (r_buf_irq && f[i2cm_pkg::FLAG_TXE] && f[i2cm_pkg::FLAG_MSL] &&
                        r_state == i2cm_pkg::ST_TX && r_tx_rem != '0) begin
                        entry.mask[i2cm_pkg::SLOT_TX_BYTE]  = 1'b1;
                        entry.slots[i2cm_pkg::SLOT_TX_BYTE] =
                            mk(i2cm_pkg::ACT_WRITE, i_req.tx_byte, '0);
                        n_tx_rem = r_tx_rem - i2cm_pkg::LEN_W'(1);
                    end
                    if (r_buf_irq && f[i2cm_pkg::FLAG_RXNE] && f[i2cm_pkg::FLAG_MSL] &&
                        r_state == i2cm_pkg::ST_RX) begin
                        if (r_rx_total != '0) begin
                            // NACK ahead of the final byte of a longer read.
                            if (r_rx_total != i2cm_pkg::LEN_W'(1) &&
                                r_rx_rem == i2cm_pkg::LEN_W'(2)) begin
                                entry.mask[i2cm_pkg::SLOT_RX_NACK]  = 1'b1;
                                entry.slots[i2cm_pkg::SLOT_RX_NACK] =
                                    mk(i2cm_pkg::ACT_ACK, '0, '0);
                            end
                            entry.mask[i2cm_pkg::SLOT_RX_BYTE]  = 1'b1;
                            entry.slots[i2cm_pkg::SLOT_RX_BYTE] =
                                mk(i2cm_pkg::ACT_RXBYTE, i_req.rx_byte, '0);
                            if (r_rx_rem != '0) begin
                                rem_new = r_rx_rem - i2cm_pkg::LEN_W'(1);
                            end
                        end
                        n_rx_rem = rem_new;
                        if (rem_new == '0) begin
                            entry.mask[i2cm_pkg::SLOT_RX_STOP]  = !r_hold;
                            entry.slots[i2cm_pkg::SLOT_RX_STOP] = mk(i2cm_pkg::ACT_STOP, '0, '0);
                            entry.mask[i2cm_pkg::SLOT_RX_ACK]   = i_ack_control;
                            entry.slots[i2cm_pkg::SLOT_RX_ACK]  =
                                mk(i2cm_pkg::ACT_ACK, i2cm_pkg::BYTE_W'(1), '0);
                            entry.mask[i2cm_pkg::SLOT_RX_DONE]  = 1'b1;
                            entry.slots[i2cm_pkg::SLOT_RX_DONE] =
                                mk(i2cm_pkg::ACT_RXDONE, '0, '0);
                            n_rx_total = '0;
                            n_state    = i2cm_pkg::ST_READY;
                            n_ev_irq   = 1'b0;
                            n_buf_irq  = 1'b0;
                            n_err_irq  = 1'b0;
                        end
                    end
                end
            end
            i2cm_pkg::FUNC_ERROR: begin
                if (r_err_irq) begin
                    for (int k = 0; k < i2cm_pkg::ERR_KINDS; k++) begin
                        entry.mask[k]  = f[k];
                        entry.slots[k] = mk(i2cm_pkg::ACT_ERROR, '0, i2cm_pkg::CODE_W'(k));
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= i2cm_pkg::ST_READY;
            r_tx_rem   <= '0;
            r_rx_rem   <= '0;
            r_rx_total <= '0;
            r_addr     <= '0;
            r_hold     <= 1'b0;
            r_ev_irq   <= 1'b0;
            r_buf_irq  <= 1'b0;
            r_err_irq  <= 1'b0;
        end else if (accept) begin
            r_state    <= n_state;
            r_tx_rem   <= n_tx_rem;
            r_rx_rem   <= n_rx_rem;
            r_rx_total <= n_rx_total;
            r_addr     <= n_addr;
            r_hold     <= n_hold;
            r_ev_irq   <= n_ev_irq;
            r_buf_irq  <= n_buf_irq;
            r_err_irq  <= n_err_irq;
        end
    end

endmodule
`default_nettype wire

// ===== src/i2cm_queue.sv =====
// Short queue of action lists between the front and back ends.
`default_nettype none
module i2cm_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  i2cm_pkg::t_entry    i_entry,
    output logic                o_full,
    input  logic                i_pop,
    output i2cm_pkg::t_entry    o_head,
    output logic                o_empty
);

    i2cm_pkg::t_entry                   r_mem [i2cm_pkg::QUEUE_DEPTH];
    logic [i2cm_pkg::QPTR_W-1:0]        r_wr, n_wr;
    logic [i2cm_pkg::QPTR_W-1:0]        r_rd, n_rd;
    logic [i2cm_pkg::QCNT_W-1:0]        r_count;

    assign o_full  = (r_count == i2cm_pkg::QCNT_W'(i2cm_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    assign n_wr = (r_wr == i2cm_pkg::QPTR_W'(i2cm_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : r_wr + i2cm_pkg::QPTR_W'(1);
    assign n_rd = (r_rd == i2cm_pkg::QPTR_W'(i2cm_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : r_rd + i2cm_pkg::QPTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + i2cm_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - i2cm_pkg::QCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/i2cm_back.sv =====
// Back end: walks the head action list and presents one action per transfer.
`default_nettype none
module i2cm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2cm_pkg::t_entry    i_head,
    input  logic                i_empty,
    output logic                o_pop,
    i2cm_rsp_if.source          o_rsp
);

    logic [i2cm_pkg::SLOT_COUNT-1:0]    r_done;
    logic                               r_valid;
    i2cm_pkg::t_act                     r_act;
    logic                               r_last;
    logic [i2cm_pkg::SLOT_COUNT-1:0]    remaining;
    logic [i2cm_pkg::SLOT_COUNT-1:0]    lowest;
    logic [i2cm_pkg::SLOT_IDX_W-1:0]    sel;
    logic                               is_last;
    logic                               load;

    assign remaining = i_empty ? '0 : (i_head.mask & ~r_done);
    assign lowest    = remaining & (~remaining + i2cm_pkg::SLOT_COUNT'(1));
    assign is_last   = ((remaining & ~lowest) == '0);
    assign load      = (!r_valid || o_rsp.ready) && (remaining != '0);
    assign o_pop     = load && is_last;

    always_comb begin
        sel = '0;
        for (int i = 0; i < i2cm_pkg::SLOT_COUNT; i++) begin
            if (lowest[i]) begin
                sel = sel | i2cm_pkg::SLOT_IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_done  <= is_last ? '0 : (r_done | lowest);
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_act  <= i_head.slots[sel];
            r_last <= is_last;
        end
    end

    assign o_rsp.valid     = r_valid;
    assign o_rsp.action    = r_act.action;
    assign o_rsp.data_byte = r_act.data;
    assign o_rsp.code      = r_act.code;
    assign o_rsp.last      = r_last;

endmodule
`default_nettype wire

// ===== src/i2cm_checker.sv =====
// Port-level checks of the transfer sequencer, bound to its top level.
`default_nettype none
module i2cm_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_ready,
    input  logic                            i_rsp_valid,
    input  logic                            i_rsp_ready,
    input  logic [i2cm_pkg::ACTION_W-1:0]   i_rsp_action,
    input  logic [i2cm_pkg::BYTE_W-1:0]     i_rsp_data,
    input  logic [i2cm_pkg::CODE_W-1:0]     i_rsp_code,
    input  logic                            i_rsp_last
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_action) &&
        $stable(i_rsp_data) && $stable(i_rsp_code) && $stable(i_rsp_last))
        else $error("stalled action changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid && i_req_ready)
        else $error("block not idle after reset");

    a_start_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_action == i2cm_pkg::ACT_START |-> !i_rsp_last)
        else $error("start action without its busy reply");

    a_closing_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_action == i2cm_pkg::ACT_BUSY ||
                        i_rsp_action == i2cm_pkg::ACT_TXDONE ||
                        i_rsp_action == i2cm_pkg::ACT_RXDONE) |-> i_rsp_last)
        else $error("closing action not marked last");

endmodule

bind i2c_master_transfer_sequencer i2cm_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_action (o_rsp.action),
    .i_rsp_data   (o_rsp.data_byte),
    .i_rsp_code   (o_rsp.code),
    .i_rsp_last   (o_rsp.last)
);
`default_nettype wire

// ===== bench/tb_i2c_master_transfer_sequencer.sv =====
// Self-checking testbench for the I2C master transfer sequencer: a directed table, then random transfers.
module tb_i2c_master_transfer_sequencer;

    localparam logic [i2cm_pkg::FUNC_W-1:0]  FUNC_UNUSED = 2'd3;
    localparam logic [i2cm_pkg::FLAGS_W-1:0] F_SB   =
        i2cm_pkg::FLAGS_W'(1 << i2cm_pkg::FLAG_SB);
    localparam logic [i2cm_pkg::FLAGS_W-1:0] F_ADDR =
        i2cm_pkg::FLAGS_W'(1 << i2cm_pkg::FLAG_ADDR);
    localparam logic [i2cm_pkg::FLAGS_W-1:0] F_BTF  =
        i2cm_pkg::FLAGS_W'(1 << i2cm_pkg::FLAG_BTF);
    localparam logic [i2cm_pkg::FLAGS_W-1:0] F_TXE  =
        i2cm_pkg::FLAGS_W'(1 << i2cm_pkg::FLAG_TXE);
    localparam logic [i2cm_pkg::FLAGS_W-1:0] F_RXNE =
        i2cm_pkg::FLAGS_W'(1 << i2cm_pkg::FLAG_RXNE);
    localparam logic [i2cm_pkg::FLAGS_W-1:0] F_MSL  =
        i2cm_pkg::FLAGS_W'(1 << i2cm_pkg::FLAG_MSL);
    localparam int            PREDICT     = -1;
    localparam i2cm_pkg::t_act NO_ACT     = '0;
    localparam int            HOLD_CYCLES = 120;
    localparam int            SETTLE      = 8;
    localparam int            LIMIT_TIME  = 5000000;

    typedef struct packed {
        logic [i2cm_pkg::FUNC_W-1:0]  func;
        logic                         dir_read;
        logic [i2cm_pkg::ADDR_W-1:0]  slave_addr;
        logic [i2cm_pkg::LEN_W-1:0]   length;
        logic                         rep_start;
        logic [i2cm_pkg::FLAGS_W-1:0] status_flags;
        logic [i2cm_pkg::BYTE_W-1:0]  rx_byte;
        logic [i2cm_pkg::BYTE_W-1:0]  tx_byte;
    } t_req;

    // One stimulus row; where typed is set, acts holds the whole expected list.
    typedef struct packed {
        t_req                 item;
        logic                 typed;
        logic [2:0]           n_exp;
        i2cm_pkg::t_act [4:0] acts;
    } t_row;

    typedef struct packed {
        i2cm_pkg::t_action           action;
        logic [i2cm_pkg::BYTE_W-1:0] data;
        logic [i2cm_pkg::CODE_W-1:0] code;
        logic                        last;
    } t_exp;

    logic clk = 1'b0;
    logic rst_n;

    i2cm_req_if req_ch ();
    i2cm_cfg_if cfg_ch ();
    i2cm_rsp_if rsp_ch ();

    i2c_master_transfer_sequencer u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Predicted transfer state; m_state holds the code a busy reply would carry.
    logic [i2cm_pkg::CODE_W-1:0] m_state;
    logic [i2cm_pkg::LEN_W-1:0]  m_tx_left;
    logic [i2cm_pkg::LEN_W-1:0]  m_rx_left;
    logic [i2cm_pkg::LEN_W-1:0]  m_rx_len;
    logic [i2cm_pkg::ADDR_W-1:0] m_addr;
    logic                        m_hold;
    logic                        m_ev_en;
    logic                        m_buf_en;
    logic                        m_err_en;
    logic                        m_ack_ctl;

    t_exp pending_actions[$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_req_cnt   = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int n_items        = 0;
    int n_result_items = 0;
    int n_checked      = 0;
    int n_closed       = 0;
    int n_fail         = 0;

    function automatic void push_action(i2cm_pkg::t_action a, logic [i2cm_pkg::BYTE_W-1:0] d,
                                        logic [i2cm_pkg::CODE_W-1:0] c);
        pending_actions.push_back(t_exp'{action: a, data: d, code: c, last: 1'b0});
    endfunction

    function automatic void close_model_transfer();
        m_ev_en  = 1'b0;
        m_buf_en = 1'b0;
        m_err_en = 1'b0;
        m_state  = i2cm_pkg::BUSY_READY;
        n_closed++;
        if (m_ack_ctl)
            push_action(i2cm_pkg::ACT_ACK, 8'h01, 3'd0);
    endfunction

    function automatic void predict_actions(input t_req r);
        int                          n_before;
        logic                        buf_en;
        logic [i2cm_pkg::CODE_W-1:0] prior;
        t_exp                        tail;
        n_before = pending_actions.size();
        buf_en   = m_buf_en;
        prior    = m_state;
        case (r.func)
            i2cm_pkg::FUNC_START: begin
                if (prior != i2cm_pkg::BUSY_TX && prior != i2cm_pkg::BUSY_RX) begin
                    if (r.dir_read) begin
                        m_rx_left = r.length;
                        m_rx_len  = r.length;
                        m_state   = i2cm_pkg::BUSY_RX;
                    end else begin
                        m_tx_left = r.length;
                        m_state   = i2cm_pkg::BUSY_TX;
                    end
                    m_addr   = r.slave_addr;
                    m_hold   = r.rep_start;
                    m_ev_en  = 1'b1;
                    m_buf_en = 1'b1;
                    m_err_en = 1'b1;
                    push_action(i2cm_pkg::ACT_START, 8'h00, 3'd0);
                end
                push_action(i2cm_pkg::ACT_BUSY, 8'h00, prior);
            end
            i2cm_pkg::FUNC_EVENT: begin
                if (m_ev_en) begin
                    if (r.status_flags[i2cm_pkg::FLAG_SB]) begin
                        if (m_state == i2cm_pkg::BUSY_TX)
                            push_action(i2cm_pkg::ACT_WRITE, {m_addr, 1'b0}, 3'd0);
                        else if (m_state == i2cm_pkg::BUSY_RX)
                            push_action(i2cm_pkg::ACT_WRITE, {m_addr, 1'b1}, 3'd0);
                    end
                    if (r.status_flags[i2cm_pkg::FLAG_ADDR]) begin
                        // A single-byte read must NACK its only byte.
                        if (m_state == i2cm_pkg::BUSY_RX && m_rx_len == 1)
                            push_action(i2cm_pkg::ACT_ACK, 8'h00, 3'd0);
                        push_action(i2cm_pkg::ACT_CLRADDR, 8'h00, 3'd0);
                    end
                    if (r.status_flags[i2cm_pkg::FLAG_BTF] &&
                        r.status_flags[i2cm_pkg::FLAG_TXE] &&
                        m_state == i2cm_pkg::BUSY_TX && m_tx_left == 0) begin
                        push_action(i2cm_pkg::ACT_STOP, 8'h00, 3'd0);
                        close_model_transfer();
                        push_action(i2cm_pkg::ACT_TXDONE, 8'h00, 3'd0);
                    end
                    if (buf_en && r.status_flags[i2cm_pkg::FLAG_TXE] &&
                        r.status_flags[i2cm_pkg::FLAG_MSL] &&
                        m_state == i2cm_pkg::BUSY_TX && m_tx_left != 0) begin
                        push_action(i2cm_pkg::ACT_WRITE, r.tx_byte, 3'd0);
                        m_tx_left--;
                    end
                    if (buf_en && r.status_flags[i2cm_pkg::FLAG_RXNE] &&
                        r.status_flags[i2cm_pkg::FLAG_MSL] &&
                        m_state == i2cm_pkg::BUSY_RX) begin
                        if (m_rx_len != 0) begin
                            if (m_rx_len > 1 && m_rx_left == 2)
                                push_action(i2cm_pkg::ACT_ACK, 8'h00, 3'd0);
                            push_action(i2cm_pkg::ACT_RXBYTE, r.rx_byte, 3'd0);
                            if (m_rx_left != 0)
                                m_rx_left--;
                        end
                        if (m_rx_left == 0) begin
                            // A repeated start keeps the bus, so no STOP here.
                            if (!m_hold)
                                push_action(i2cm_pkg::ACT_STOP, 8'h00, 3'd0);
                            m_rx_len = '0;
                            close_model_transfer();
                            push_action(i2cm_pkg::ACT_RXDONE, 8'h00, 3'd0);
                        end
                    end
                end
            end
            i2cm_pkg::FUNC_ERROR: begin
                if (m_err_en)
                    for (int k = 0; k < i2cm_pkg::ERR_KINDS; k++)
                        if (r.status_flags[k])
                            push_action(i2cm_pkg::ACT_ERROR, 8'h00,
                                        k[i2cm_pkg::CODE_W-1:0]);
            end
            default: ;
        endcase
        if (pending_actions.size() > n_before) begin
            tail      = pending_actions.pop_back();
            tail.last = 1'b1;
            pending_actions.push_back(tail);
        end
    endfunction

    function automatic i2cm_pkg::t_act mk_act(i2cm_pkg::t_action a,
                                              logic [i2cm_pkg::BYTE_W-1:0] d,
                                              logic [i2cm_pkg::CODE_W-1:0] c);
        return i2cm_pkg::t_act'{action: a, data: d, code: c};
    endfunction

    function automatic t_row mk_row(logic [i2cm_pkg::FUNC_W-1:0] f, logic d,
                                    logic [i2cm_pkg::ADDR_W-1:0] a,
                                    logic [i2cm_pkg::LEN_W-1:0] l, logic rp,
                                    logic [i2cm_pkg::FLAGS_W-1:0] fl,
                                    logic [i2cm_pkg::BYTE_W-1:0] rx,
                                    logic [i2cm_pkg::BYTE_W-1:0] tx,
                                    int n_typed, i2cm_pkg::t_act a0, i2cm_pkg::t_act a1);
        t_row r;
        r                   = '0;
        r.item.func         = f;
        r.item.dir_read     = d;
        r.item.slave_addr   = a;
        r.item.length       = l;
        r.item.rep_start    = rp;
        r.item.status_flags = fl;
        r.item.rx_byte      = rx;
        r.item.tx_byte      = tx;
        r.typed             = (n_typed >= 0);
        r.n_exp             = (n_typed >= 0) ? n_typed[2:0] : 3'd0;
        r.acts[0]           = a0;
        r.acts[1]           = a1;
        return r;
    endfunction

    function automatic t_row rand_row();
        return mk_row(i2cm_pkg::FUNC_W'($urandom_range(0, 3)), 1'($urandom),
                      i2cm_pkg::ADDR_W'($urandom), i2cm_pkg::LEN_W'($urandom),
                      1'($urandom), i2cm_pkg::FLAGS_W'($urandom),
                      i2cm_pkg::BYTE_W'($urandom), i2cm_pkg::BYTE_W'($urandom),
                      PREDICT, NO_ACT, NO_ACT);
    endfunction

    function automatic logic [i2cm_pkg::LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return i2cm_pkg::LEN_W'($urandom_range(0, 3));
        else if (r < 95)
            return i2cm_pkg::LEN_W'($urandom_range(4, 12));
        return i2cm_pkg::LEN_W'($urandom_range(13, 40));
    endfunction

    task automatic drive_item(input t_row row);
        int n_before;
        while ($urandom_range(0, 99) < send_idle_pct)
            @(negedge clk);
        req_ch.func         = row.item.func;
        req_ch.dir_read     = row.item.dir_read;
        req_ch.slave_addr   = row.item.slave_addr;
        req_ch.length       = row.item.length;
        req_ch.rep_start    = row.item.rep_start;
        req_ch.status_flags = row.item.status_flags;
        req_ch.rx_byte      = row.item.rx_byte;
        req_ch.tx_byte      = row.item.tx_byte;
        req_ch.valid        = 1'b1;
        do @(posedge clk); while (!req_ch.ready);
        n_before = pending_actions.size();
        predict_actions(row.item);
        if (row.typed) begin
            // The predictor still tracks state; the typed list replaces its output.
            while (pending_actions.size() > n_before)
                void'(pending_actions.pop_back());
            for (int k = 0; k < row.n_exp; k++)
                pending_actions.push_back(t_exp'{action: row.acts[k].action,
                                                 data: row.acts[k].data,
                                                 code: row.acts[k].code,
                                                 last: (k == row.n_exp - 1)});
        end
        n_items++;
        if (pending_actions.size() > n_before)
            n_result_items++;
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic write_ack_control(input logic v);
        cfg_ch.ack_control = v;
        cfg_ch.valid       = 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        m_ack_ctl = v;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic wait_quiet();
        while (pending_actions.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // One bus transaction: maybe a stray item, a start, then mostly well-formed events until it closes.
    task automatic run_transfer();
        t_row                         row;
        int                           steps;
        logic [i2cm_pkg::FLAGS_W-1:0] fl;
        if ($urandom_range(0, 9) == 0) begin
            row = rand_row();
            row.item.func = i2cm_pkg::FUNC_W'($urandom_range(1, 3));
            drive_item(row);
        end
        row = rand_row();
        row.item.func   = i2cm_pkg::FUNC_START;
        row.item.length = pick_length();
        drive_item(row);
        steps = 0;
        while (m_state != i2cm_pkg::BUSY_READY && steps < 500) begin
            row = rand_row();
            if ($urandom_range(0, 99) >= 12) begin
                if (steps == 0)
                    fl = F_SB;
                else if (steps == 1)
                    fl = F_ADDR;
                else if (m_state == i2cm_pkg::BUSY_RX)
                    fl = F_RXNE | F_MSL;
                else if (m_tx_left == 0)
                    fl = F_BTF | F_TXE | F_MSL;
                else
                    fl = F_TXE | F_MSL;
                row.item.func         = i2cm_pkg::FUNC_EVENT;
                row.item.status_flags = fl;
            end
            drive_item(row);
            steps++;
        end
    endtask

    task automatic run_phase(input int target);
        int goal;
        goal = n_items + target;
        while (n_items < goal)
            run_transfer();
    endtask

    // Output side: random back-pressure, plus a long hold-off on request.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end else if (hold_seen != hold_req_cnt) begin
                hold_seen    = hold_req_cnt;
                hold_left    = HOLD_CYCLES - 1;
                rsp_ch.ready = 1'b0;
            end else begin
                rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        t_exp want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_actions.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("%0t: unexpected action %0d data %02h code %0d last %0d",
                             $time, rsp_ch.action, rsp_ch.data_byte, rsp_ch.code,
                             rsp_ch.last);
            end else begin
                want = pending_actions.pop_front();
                n_checked++;
                if (rsp_ch.action !== want.action || rsp_ch.data_byte !== want.data ||
                    rsp_ch.code !== want.code || rsp_ch.last !== want.last) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("%0t: expected %0d/%02h/%0d/%0d, got %0d/%02h/%0d/%0d",
                                 $time, want.action, want.data, want.code, want.last,
                                 rsp_ch.action, rsp_ch.data_byte, rsp_ch.code, rsp_ch.last);
                end
            end
        end
    end

    initial begin
        #(LIMIT_TIME);
        $display("i2c_master_transfer_sequencer regression: fail");
        $finish;
    end

    initial begin
        t_row dir_table[$];
        t_row row;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.func         = i2cm_pkg::FUNC_START;
        req_ch.dir_read     = 1'b0;
        req_ch.slave_addr   = '0;
        req_ch.length       = '0;
        req_ch.rep_start    = 1'b0;
        req_ch.status_flags = '0;
        req_ch.rx_byte      = '0;
        req_ch.tx_byte      = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.ack_control  = 1'b0;
        m_state   = i2cm_pkg::BUSY_READY;
        m_tx_left = '0;
        m_rx_left = '0;
        m_rx_len  = '0;
        m_addr    = '0;
        m_hold    = 1'b0;
        m_ev_en   = 1'b0;
        m_buf_en  = 1'b0;
        m_err_en  = 1'b0;
        m_ack_ctl = 1'b0;
        send_idle_pct = 17;
        recv_idle_pct = 83;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        write_ack_control(1'b1);

        // Interrupts are off after reset, so events and errors are dropped.
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_EVENT, 1'b1, 7'h7F, 16'hFFFF, 1'b1, 6'h3F,
                                   8'hFF, 8'hFF, 0, NO_ACT, NO_ACT));
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_ERROR, 1'b0, 7'h00, 16'h0000, 1'b0, 6'h3F,
                                   8'h00, 8'h00, 0, NO_ACT, NO_ACT));
        dir_table.push_back(mk_row(FUNC_UNUSED, 1'b1, 7'h7F, 16'hFFFF, 1'b1, 6'h3F,
                                   8'hFF, 8'hFF, 0, NO_ACT, NO_ACT));
        // Zero-length write to the highest address.
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_START, 1'b0, 7'h7F, 16'h0000, 1'b1, 6'h00,
                                   8'h00, 8'h00, 2,
                                   mk_act(i2cm_pkg::ACT_START, 8'h00, 3'd0),
                                   mk_act(i2cm_pkg::ACT_BUSY, 8'h00, i2cm_pkg::BUSY_READY)));
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_START, 1'b1, 7'h00, 16'hFFFF, 1'b0, 6'h00,
                                   8'h00, 8'h00, 1,
                                   mk_act(i2cm_pkg::ACT_BUSY, 8'h00, i2cm_pkg::BUSY_TX),
                                   NO_ACT));
        row = mk_row(i2cm_pkg::FUNC_ERROR, 1'b0, 7'h00, 16'h0000, 1'b0, 6'h1F, 8'h00, 8'h00,
                     i2cm_pkg::ERR_KINDS, NO_ACT, NO_ACT);
        for (int k = 0; k < i2cm_pkg::ERR_KINDS; k++)
            row.acts[k] = mk_act(i2cm_pkg::ACT_ERROR, 8'h00, k[i2cm_pkg::CODE_W-1:0]);
        dir_table.push_back(row);
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_EVENT, 1'b0, 7'h00, 16'h0000, 1'b0, F_SB,
                                   8'h00, 8'h00, PREDICT, NO_ACT, NO_ACT));
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_EVENT, 1'b0, 7'h00, 16'h0000, 1'b0, F_ADDR,
                                   8'h00, 8'h00, PREDICT, NO_ACT, NO_ACT));
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_EVENT, 1'b0, 7'h00, 16'h0000, 1'b0,
                                   F_TXE | F_MSL, 8'h00, 8'hC3, PREDICT, NO_ACT, NO_ACT));
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_EVENT, 1'b0, 7'h00, 16'h0000, 1'b0,
                                   F_BTF | F_TXE | F_MSL, 8'h00, 8'h00, PREDICT,
                                   NO_ACT, NO_ACT));
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_EVENT, 1'b0, 7'h00, 16'h0000, 1'b0, 6'h3F,
                                   8'hFF, 8'hFF, 0, NO_ACT, NO_ACT));
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_ERROR, 1'b0, 7'h00, 16'h0000, 1'b0, 6'h1F,
                                   8'h00, 8'h00, 0, NO_ACT, NO_ACT));
        // Single-byte read to address zero, closed with STOP.
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_START, 1'b1, 7'h00, 16'h0001, 1'b0, 6'h00,
                                   8'h00, 8'h00, 2,
                                   mk_act(i2cm_pkg::ACT_START, 8'h00, 3'd0),
                                   mk_act(i2cm_pkg::ACT_BUSY, 8'h00, i2cm_pkg::BUSY_READY)));
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_EVENT, 1'b0, 7'h00, 16'h0000, 1'b0, F_SB,
                                   8'h00, 8'h00, PREDICT, NO_ACT, NO_ACT));
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_EVENT, 1'b0, 7'h00, 16'h0000, 1'b0, F_ADDR,
                                   8'h00, 8'h00, PREDICT, NO_ACT, NO_ACT));
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_EVENT, 1'b0, 7'h00, 16'h0000, 1'b0,
                                   F_RXNE | F_MSL, 8'hA5, 8'h00, PREDICT, NO_ACT, NO_ACT));
        // Three-byte read with repeated start, so the bus is kept at the end.
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_START, 1'b1, 7'h55, 16'h0003, 1'b1, 6'h00,
                                   8'h00, 8'h00, PREDICT, NO_ACT, NO_ACT));
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_START, 1'b0, 7'h2A, 16'h8000, 1'b0, 6'h00,
                                   8'h00, 8'h00, 1,
                                   mk_act(i2cm_pkg::ACT_BUSY, 8'h00, i2cm_pkg::BUSY_RX),
                                   NO_ACT));
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_EVENT, 1'b0, 7'h00, 16'h0000, 1'b0,
                                   F_SB | F_ADDR, 8'h00, 8'h00, PREDICT, NO_ACT, NO_ACT));
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_EVENT, 1'b0, 7'h00, 16'h0000, 1'b0, F_RXNE,
                                   8'h3C, 8'h00, PREDICT, NO_ACT, NO_ACT));
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_EVENT, 1'b0, 7'h00, 16'h0000, 1'b0,
                                   F_RXNE | F_MSL, 8'h00, 8'h00, PREDICT, NO_ACT, NO_ACT));
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_EVENT, 1'b0, 7'h00, 16'h0000, 1'b0,
                                   F_RXNE | F_MSL, 8'hFF, 8'h00, PREDICT, NO_ACT, NO_ACT));
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_EVENT, 1'b0, 7'h00, 16'h0000, 1'b0,
                                   F_RXNE | F_MSL, 8'h5A, 8'h00, PREDICT, NO_ACT, NO_ACT));
        // Zero-length read closes at the first received-byte event.
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_START, 1'b1, 7'h2A, 16'h0000, 1'b0, 6'h00,
                                   8'h00, 8'h00, PREDICT, NO_ACT, NO_ACT));
        dir_table.push_back(mk_row(i2cm_pkg::FUNC_EVENT, 1'b0, 7'h00, 16'h0000, 1'b0,
                                   F_RXNE | F_MSL, 8'h77, 8'h00, PREDICT, NO_ACT, NO_ACT));

        foreach (dir_table[i])
            drive_item(dir_table[i]);

        wait_quiet();
        write_ack_control(1'b0);
        run_phase(125);

        wait_quiet();
        send_idle_pct = 83;
        recv_idle_pct = 17;
        write_ack_control(1'b1);
        run_phase(125);

        wait_quiet();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_ack_control(1'b0);
        hold_req_cnt++;
        run_phase(125);

        wait_quiet();
        $display("Covered %0d request items (%0d directed, %0d with actions), %0d actions checked.",
                 n_items, dir_table.size(), n_result_items, n_checked);
        $display("%0d bus transactions closed; ack_control went 1, 0, 1, 0 over three stall mixes.",
                 n_closed);
        if (n_fail == 0)
            $display("i2c_master_transfer_sequencer regression: pass");
        else
            $display("i2c_master_transfer_sequencer regression: fail");
        $finish;
    end

endmodule
